>>> hw/rtl/wrrrq_pkg.sv
// Shared types and constants for the weighted round-robin run queue.
// No dependencies; used by the datapath, controller and top level.
`default_nettype none
package wrrrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int KIND_W  = 3;
  localparam int TASK_W  = 6;
  localparam int WGT_W   = 5;
  localparam int SLICE_W = 8;
  localparam int BASE_W  = 4;
  localparam int LEN_W   = 7;
  localparam int SUM_W   = 11;
  localparam int ERR_W   = 2;

  localparam int NUM_TASKS  = 1 << TASK_W;
  localparam int MAX_WEIGHT = 20;

  localparam logic [BASE_W-1:0] BASE_RESET = 4'd10;
  localparam logic [LEN_W-1:0]  LEN_MAX    = 7'd127;
  localparam logic [SUM_W-1:0]  SUM_MAX    = 11'd2047;

  // request kinds
  localparam logic [KIND_W-1:0] K_ENQ    = 3'd0;
  localparam logic [KIND_W-1:0] K_DEQ    = 3'd1;
  localparam logic [KIND_W-1:0] K_TICK   = 3'd2;
  localparam logic [KIND_W-1:0] K_YIELD  = 3'd3;
  localparam logic [KIND_W-1:0] K_RESCHED = 3'd4;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_REFUSE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ABSENT = 2'd2;

  typedef struct packed {
    logic [TASK_W-1:0]  task_id;
    logic [WGT_W-1:0]   wgt;
    logic [SLICE_W-1:0] slice;
  } ent_t;

  // controller -> datapath
  typedef struct packed {
    logic             latch;     // capture input beat
    logic             set_err;
    logic [ERR_W-1:0] err_code;
    logic             enq;       // append new entry at tail
    logic             rd_head;   // read entry at head
    logic             tick_dec;  // write head back with slice - 1
    logic             rotate;    // copy head entry to tail, advance head
    logic             reload;    // with rotate: reload slice, flag resched
    logic             scan_rd;   // read entry at scan index
    logic             scan_next;
    logic             found;     // keep matched entry
    logic             sh_rd;     // read entry at index + 1
    logic             sh_wr;     // write it at index, index++
    logic             fin_deq;   // drop matched entry from count/sum/map
    logic             fin_rs;    // write matched entry at last position
    logic             load_out;  // capture result beat
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              hit;        // latched task id is queued
    logic              empty;
    logic              full;
    logic              wgt_ok;
    logic              slice_gt1;  // read entry slice above one
    logic              match;      // read entry holds latched task id
    logic              last_scan;  // index + 1 >= count
    logic              last_shift; // index + 2 >= count
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/wrrrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wrrrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/wrrrq_dp.sv
// Datapath: circular entry store, head pointer, count, weight sum, task map,
// scan index and result registers. Depends on wrrrq_pkg and wrrrq_ram.
`default_nettype none
module wrrrq_dp #(
  parameter int QUEUE_DEPTH = wrrrq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [wrrrq_pkg::BASE_W-1:0]     cfg_wdata,
  input  wire [wrrrq_pkg::KIND_W-1:0]     in_kind,
  input  wire [wrrrq_pkg::TASK_W-1:0]     in_task_id,
  input  wire [wrrrq_pkg::WGT_W-1:0]      in_task_weight,
  input  wrrrq_pkg::cmd_t                 cmd,
  output wrrrq_pkg::sts_t                 sts,
  output logic [wrrrq_pkg::TASK_W-1:0]    out_head_task,
  output logic                            out_head_valid,
  output logic [wrrrq_pkg::LEN_W-1:0]     out_queue_length,
  output logic [wrrrq_pkg::SUM_W-1:0]     out_weight_sum,
  output logic                            out_resched,
  output logic [wrrrq_pkg::ERR_W-1:0]     out_error
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W = $clog2(wrrrq_pkg::MAX_WEIGHT * QUEUE_DEPTH + 1);
  localparam logic [CNT_W:0]   DEPTH_X = (CNT_W+1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // sum of two values below 2*depth, folded back into the ring
  function automatic logic [IDX_W-1:0] wrap(input logic [CNT_W:0] s);
    logic [CNT_W:0] t;
    t = (s >= DEPTH_X) ? s - DEPTH_X : s;
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [wrrrq_pkg::SLICE_W-1:0] full_slice(
    input logic [wrrrq_pkg::BASE_W-1:0] b,
    input logic [wrrrq_pkg::WGT_W-1:0]  w
  );
    logic [8:0] p;
    p = 9'(b) * 9'(w);
    return (p > 9'd255) ? 8'hFF : p[7:0];
  endfunction

  logic [wrrrq_pkg::BASE_W-1:0] base_r;
  logic [IDX_W-1:0]             hd_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [TOT_W-1:0]             tot_r;
  logic [wrrrq_pkg::NUM_TASKS-1:0] map_r;
  logic [IDX_W-1:0]             idx_r;
  logic [wrrrq_pkg::KIND_W-1:0] kind_r;
  logic [wrrrq_pkg::TASK_W-1:0] id_r;
  logic [wrrrq_pkg::WGT_W-1:0]  w_r;
  logic [wrrrq_pkg::ERR_W-1:0]  err_r;
  logic                         rs_r;
  wrrrq_pkg::ent_t              ent_r;

  wrrrq_pkg::ent_t  rdata;
  wrrrq_pkg::ent_t  wdata;
  logic             we;
  logic             re;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;

  logic [CNT_W:0]   hd_x;
  logic [CNT_W:0]   idx_x;
  logic [IDX_W-1:0] pos_i;
  logic [IDX_W-1:0] pos_i1;
  logic [IDX_W-1:0] pos_tail;
  logic [IDX_W-1:0] pos_last;
  logic [IDX_W-1:0] hd_inc;

  assign hd_x     = (CNT_W+1)'(hd_r);
  assign idx_x    = (CNT_W+1)'(idx_r);
  assign pos_i    = wrap(hd_x + idx_x);
  assign pos_i1   = wrap(hd_x + idx_x + (CNT_W+1)'(1));
  assign pos_tail = wrap(hd_x + (CNT_W+1)'(cnt_r));
  assign pos_last = wrap(hd_x + (CNT_W+1)'(cnt_r) - (CNT_W+1)'(1));
  assign hd_inc   = wrap(hd_x + (CNT_W+1)'(1));

  // memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = pos_tail;
    wdata = rdata;
    re    = 1'b0;
    raddr = hd_r;
    if (cmd.enq) begin
      we    = 1'b1;
      wdata = '{task_id: id_r, wgt: w_r, slice: full_slice(base_r, w_r)};
    end
    if (cmd.tick_dec) begin
      we    = 1'b1;
      waddr = hd_r;
      wdata = '{task_id: rdata.task_id, wgt: rdata.wgt,
                slice: rdata.slice - 8'd1};
    end
    if (cmd.rotate) begin
      we = 1'b1;
      if (cmd.reload) begin
        wdata.slice = full_slice(base_r, rdata.wgt);
      end
    end
    if (cmd.sh_wr) begin
      we    = 1'b1;
      waddr = pos_i;
    end
    if (cmd.fin_rs) begin
      we    = 1'b1;
      waddr = pos_last;
      wdata = ent_r;
    end
    if (cmd.rd_head) begin
      re = 1'b1;
    end
    if (cmd.scan_rd) begin
      re    = 1'b1;
      raddr = pos_i;
    end
    if (cmd.sh_rd) begin
      re    = 1'b1;
      raddr = pos_i1;
    end
  end

  wrrrq_ram #(
    .WIDTH($bits(wrrrq_pkg::ent_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    sts.kind       = kind_r;
    sts.hit        = map_r[id_r];
    sts.empty      = (cnt_r == '0);
    sts.full       = (cnt_r >= DEPTH_C);
    sts.wgt_ok     = (w_r != '0) && (32'(w_r) <= wrrrq_pkg::MAX_WEIGHT);
    sts.slice_gt1  = (rdata.slice > 8'd1);
    sts.match      = (rdata.task_id == id_r);
    sts.last_scan  = ((idx_x + (CNT_W+1)'(1)) >= (CNT_W+1)'(cnt_r));
    sts.last_shift = ((idx_x + (CNT_W+1)'(2)) >= (CNT_W+1)'(cnt_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= wrrrq_pkg::BASE_RESET;
      hd_r   <= '0;
      cnt_r  <= '0;
      tot_r  <= '0;
      map_r  <= '0;
      idx_r  <= '0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (cmd.latch) begin
        idx_r <= '0;
      end
      if (cmd.enq) begin
        cnt_r        <= cnt_r + CNT_W'(1);
        tot_r        <= tot_r + TOT_W'(w_r);
        map_r[id_r]  <= 1'b1;
      end
      if (cmd.rotate) begin
        hd_r <= hd_inc;
      end
      if (cmd.scan_next || cmd.sh_wr) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.fin_deq) begin
        cnt_r       <= cnt_r - CNT_W'(1);
        tot_r       <= tot_r - TOT_W'(ent_r.wgt);
        map_r[id_r] <= 1'b0;
      end
    end
  end

  // beat capture, per-request flags, matched entry and result beat
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      id_r   <= in_task_id;
      w_r    <= in_task_weight;
      err_r  <= wrrrq_pkg::ERR_OK;
      rs_r   <= 1'b0;
    end
    if (cmd.set_err) begin
      err_r <= cmd.err_code;
    end
    if (cmd.rotate && cmd.reload) begin
      rs_r <= 1'b1;
    end
    if (cmd.found) begin
      ent_r <= rdata;
    end
    if (cmd.load_out) begin
      out_head_task    <= (cnt_r != '0) ? rdata.task_id : '0;
      out_head_valid   <= (cnt_r != '0);
      out_queue_length <= (32'(cnt_r) > 32'(wrrrq_pkg::LEN_MAX)) ?
                          wrrrq_pkg::LEN_MAX : wrrrq_pkg::LEN_W'(cnt_r);
      out_weight_sum   <= (32'(tot_r) > 32'(wrrrq_pkg::SUM_MAX)) ?
                          wrrrq_pkg::SUM_MAX : wrrrq_pkg::SUM_W'(tot_r);
      out_resched      <= rs_r;
      out_error        <= err_r;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/wrrrq_ctrl.sv
// Controller state machine: sequences decode, head update, scan and
// compaction, then the result beat. Depends on wrrrq_pkg.
`default_nettype none
module wrrrq_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  wrrrq_pkg::sts_t  sts,
  output wrrrq_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_HREAD   = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_SCAN_CM = 4'd4;
  localparam logic [3:0] S_SH_RD   = 4'd5;
  localparam logic [3:0] S_SH_WR   = 4'd6;
  localparam logic [3:0] S_FIN     = 4'd7;
  localparam logic [3:0] S_HEAD    = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       ovld_r;
  logic       ovld_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;
  assign out_free  = !ovld_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ovld_nxt  = ovld_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_HEAD;
        unique case (sts.kind)
          wrrrq_pkg::K_ENQ: begin
            if (!sts.wgt_ok || sts.full || sts.hit) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = wrrrq_pkg::ERR_REFUSE;
            end else begin
              cmd.enq = 1'b1;
            end
          end
          wrrrq_pkg::K_DEQ, wrrrq_pkg::K_RESCHED: begin
            if (!sts.hit) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = wrrrq_pkg::ERR_ABSENT;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          wrrrq_pkg::K_TICK, wrrrq_pkg::K_YIELD: begin
            if (sts.empty) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = wrrrq_pkg::ERR_ABSENT;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_HREAD;
            end
          end
          default: ;
        endcase
      end
      S_HREAD: begin
        // tick with slice left only decrements; else head goes to tail
        if (sts.kind == wrrrq_pkg::K_TICK && sts.slice_gt1) begin
          cmd.tick_dec = 1'b1;
        end else begin
          cmd.rotate = 1'b1;
          cmd.reload = (sts.kind == wrrrq_pkg::K_TICK);
        end
        state_nxt = S_HEAD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CM;
      end
      S_SCAN_CM: begin
        if (sts.match) begin
          cmd.found = 1'b1;
          state_nxt = sts.last_scan ? S_FIN : S_SH_RD;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        cmd.sh_rd = 1'b1;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = sts.last_shift ? S_FIN : S_SH_RD;
      end
      S_FIN: begin
        if (sts.kind == wrrrq_pkg::K_DEQ) begin
          cmd.fin_deq = 1'b1;
        end else begin
          cmd.fin_rs = 1'b1;
        end
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd.rd_head = !sts.empty;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/weighted_round_robin_run_queue.sv
// Weighted round-robin run queue, top level: controller, datapath, RAM.
// Enqueue, errors, unknown kinds: decode, head read, then the result beat.
// Tick and yield: decode, head update, head re-read, then the result beat.
// Dequeue/reschedule: decode, a one-port scan of the entries up to the task,
// compaction of every later entry, then the final update and result beat.
// One request at a time; a held result beat (out_ready low) stalls the next.
// Reset (sync, active low) clears count, sum, task map and handshake state;
// base_slice returns to 10. Entry RAM is not cleared.
`default_nettype none
module weighted_round_robin_run_queue #(
  parameter int QUEUE_DEPTH = wrrrq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire [wrrrq_pkg::BASE_W-1:0]   cfg_wdata,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [wrrrq_pkg::KIND_W-1:0]   in_kind,
  input  wire [wrrrq_pkg::TASK_W-1:0]   in_task_id,
  input  wire [wrrrq_pkg::WGT_W-1:0]    in_task_weight,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [wrrrq_pkg::TASK_W-1:0]  out_head_task,
  output logic                          out_head_valid,
  output logic [wrrrq_pkg::LEN_W-1:0]   out_queue_length,
  output logic [wrrrq_pkg::SUM_W-1:0]   out_weight_sum,
  output logic                          out_resched,
  output logic [wrrrq_pkg::ERR_W-1:0]   out_error
);

  wrrrq_pkg::cmd_t cmd;
  wrrrq_pkg::sts_t sts;

  wrrrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrrrq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_kind),
    .in_task_id      (in_task_id),
    .in_task_weight  (in_task_weight),
    .cmd             (cmd),
    .sts             (sts),
    .out_head_task   (out_head_task),
    .out_head_valid  (out_head_valid),
    .out_queue_length(out_queue_length),
    .out_weight_sum  (out_weight_sum),
    .out_resched     (out_resched),
    .out_error       (out_error)
  );

  // one request in flight at a time
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in flight");

  a_head_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_queue_length != '0)))
    else $error("head_valid disagrees with queue length");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_head_valid |-> (out_weight_sum == '0))
    else $error("empty queue with nonzero weight sum");

  a_resched_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resched |-> (out_error == wrrrq_pkg::ERR_OK))
    else $error("reschedule flagged on a failed request");

endmodule
`default_nettype wire
